// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the projection RTL.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define AP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define AP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AP_ASSERT(lbl, clk, rst, prop, msg)
`define AP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/app_pkg.sv =====
// Shared types, widths and constants for the angular point projection.
// No dependencies; every module of the block imports it.
package app_pkg;

  localparam int SCREEN_WIDTH_DEF  = 100;
  localparam int SCREEN_HEIGHT_DEF = 100;

  localparam int COORD_W = 16;
  localparam int DELTA_W = COORD_W + 1;
  localparam int ROT_W   = 15;
  localparam int FOV_W   = 14;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 3;

  // planar distance squared and its Q12 root
  localparam int SQ_W     = 2 * (DELTA_W - 1) + 2;
  localparam int ROOT_W   = (SQ_W + 24) / 2;
  localparam int SQRT_LAT = 2 + ROOT_W;

  localparam int CORD_W       = 32;
  localparam int Z_W          = 24;
  localparam int ANG_W        = 16;
  localparam int CORDIC_STEPS = 20;
  localparam logic signed [Z_W-1:0] PI_Q20 = 24'sd3294199;

  typedef enum logic [ADDR_W-1:0] {
    REG_CAM_POS_X = 3'd0,
    REG_CAM_POS_Y = 3'd1,
    REG_CAM_POS_Z = 3'd2,
    REG_CAM_YAW   = 3'd3,
    REG_CAM_PITCH = 3'd4,
    REG_FOV       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] screen_col;
    logic signed [15:0] screen_row;
  } screen_t;

  // atan(2^-i) in Q20
  function automatic logic signed [Z_W-1:0] atan_q20(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = 24'sd823550;
      1:  v = 24'sd486170;
      2:  v = 24'sd256879;
      3:  v = 24'sd130396;
      4:  v = 24'sd65451;
      5:  v = 24'sd32757;
      6:  v = 24'sd16383;
      7:  v = 24'sd8192;
      8:  v = 24'sd4096;
      9:  v = 24'sd2048;
      10: v = 24'sd1024;
      11: v = 24'sd512;
      12: v = 24'sd256;
      13: v = 24'sd128;
      14: v = 24'sd64;
      15: v = 24'sd32;
      16: v = 24'sd16;
      17: v = 24'sd8;
      18: v = 24'sd4;
      19: v = 24'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/app_sqrt.sv =====
// Pipelined planar distance: squares, sum, then one root bit per stage.
// Depends on app_pkg for widths.
module app_sqrt
  import app_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic signed [DELTA_W-1:0] dx,
  input  logic signed [DELTA_W-1:0] dy,
  output logic                      out_vld,
  output logic [ROOT_W-1:0]         root
);

  localparam int VW    = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int T_W   = REM_W + 3;

  logic signed [2*DELTA_W-1:0] pa, pb;
  logic [SQ_W-2:0] sqa, sqb;
  logic            vld_m;

  logic [REM_W-1:0]  rem [0:ROOT_W];
  logic [ROOT_W-1:0] q   [0:ROOT_W];
  logic [VW-1:0]     v   [0:ROOT_W];
  logic              vld [0:ROOT_W];

  assign pa = dx * dx;
  assign pb = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m  <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      vld_m  <= in_vld;
      vld[0] <= vld_m;
    end
    if (en) begin
      sqa    <= pa[SQ_W-2:0];
      sqb    <= pb[SQ_W-2:0];
      v[0]   <= {({1'b0, sqa} + {1'b0, sqb}), {(VW-SQ_W){1'b0}}};
      rem[0] <= '0;
      q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [T_W-1:0] a, b, t;
    logic           ge;
    always_comb begin
      a  = {1'b0, rem[k], v[k][VW-1:VW-2]};
      b  = {{(T_W-ROOT_W-2){1'b0}}, q[k], 2'b01};
      t  = a - b;
      ge = !t[T_W-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1] <= ge ? t[REM_W-1:0] : a[REM_W-1:0];
        q[k+1]   <= {q[k][ROOT_W-2:0], ge};
        v[k+1]   <= {v[k][VW-3:0], 2'b00};
      end
    end
  end

  assign out_vld = vld[ROOT_W];
  assign root    = q[ROOT_W];

endmodule

// ===== rtl/app_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in Q12, one micro-rotation per stage.
// Depends on app_pkg for widths and the arctangent table.
module app_cordic
  import app_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [CORD_W-1:0] x,
  input  logic signed [CORD_W-1:0] y,
  output logic                     out_vld,
  output logic signed [ANG_W-1:0]  angle
);

  logic signed [CORD_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [CORD_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]    zs [0:CORDIC_STEPS];
  logic                     zf [0:CORDIC_STEPS];
  logic                     vld [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]    zr;
  logic                     vld_o;

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      zf[0] <= (x == '0) && (y == '0);
      if (x[CORD_W-1]) begin
        xs[0] <= -x;
        ys[0] <= -y;
        zs[0] <= y[CORD_W-1] ? -PI_Q20 : PI_Q20;
      end else begin
        xs[0] <= x;
        ys[0] <= y;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [Z_W-1:0] TAB = atan_q20(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        zf[i+1] <= zf[i];
        if (!ys[i][CORD_W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + TAB;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - TAB;
        end
      end
    end
  end

  assign zr = (zs[CORDIC_STEPS] + Z_W'(128)) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld[CORDIC_STEPS];
    end
    if (en) begin
      angle <= zf[CORDIC_STEPS] ? '0 : zr[ANG_W-1:0];
    end
  end

  assign out_vld = vld_o;

endmodule

// ===== rtl/app_div.sv =====
// Angle to screen coordinate: offset, scale, restoring divide by the field
// of view one quotient bit per stage, recenter and saturate. Uses app_pkg.
module app_div
  import app_pkg::*;
#(
  parameter int SIZE = SCREEN_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [ANG_W-1:0] ang,
  input  logic signed [ROT_W-1:0] off,
  input  logic [FOV_W-1:0]        fov,
  output logic                    out_vld,
  output logic signed [15:0]      result
);

  localparam int HALF    = SIZE / 2;
  localparam int SCALE   = 2 * HALF;
  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int D_W     = ANG_W + 1;
  localparam int N_W     = D_W + SCALE_W;
  localparam logic signed [SCALE_W:0] SCALE_S = (SCALE_W + 1)'(SCALE);

  logic signed [D_W-1:0]         dd;
  logic signed [D_W+SCALE_W:0]   prod;
  logic signed [N_W-1:0]         n0;
  logic                          vld0;

  logic [FOV_W-1:0] rem [0:N_W];
  logic [N_W-1:0]   uq  [0:N_W];
  logic             neg [0:N_W];
  logic             vld [0:N_W];

  logic signed [N_W+1:0] qs, sv;
  logic                  vld_o;

  assign dd   = $signed({ang[ANG_W-1], ang}) - $signed({{(D_W-ROT_W){off[ROT_W-1]}}, off});
  assign prod = dd * SCALE_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0   <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      vld0   <= in_vld;
      vld[0] <= vld0;
    end
    if (en) begin
      n0     <= prod[N_W-1:0];
      neg[0] <= n0[N_W-1];
      uq[0]  <= n0[N_W-1] ? N_W'(-n0) : N_W'(n0);
      rem[0] <= '0;
    end
  end

  for (genvar k = 0; k < N_W; k++) begin : g_bit
    logic [FOV_W:0] r2, df;
    logic           ge;
    always_comb begin
      r2 = {rem[k], uq[k][N_W-1]};
      df = r2 - {1'b0, fov};
      ge = r2 >= {1'b0, fov};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        neg[k+1] <= neg[k];
        rem[k+1] <= ge ? df[FOV_W-1:0] : r2[FOV_W-1:0];
        uq[k+1]  <= {uq[k][N_W-2:0], ge};
      end
    end
  end

  // truncation toward zero: divide the magnitude, then restore the sign
  always_comb begin
    qs = $signed({2'b00, uq[N_W]});
    if (neg[N_W]) begin
      qs = -qs;
    end
    sv = qs + (N_W + 2)'(HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld[N_W];
    end
    if (en) begin
      if (sv > $signed((N_W + 2)'(32767))) begin
        result <= 16'sh7fff;
      end else if (sv < -$signed((N_W + 2)'(32768))) begin
        result <= 16'sh8000;
      end else begin
        result <= sv[15:0];
      end
    end
  end

  assign out_vld = vld_o;

endmodule

// ===== rtl/angular_point_projection.sv =====
// Angular point projection: world point in, screen column and row out.
// Depends on app_pkg, app_sqrt, app_cordic, app_div and assert_macros.svh.
//
// Points arrive on the point channel (point_valid / point_stall) and results
// leave on the screen channel (screen_valid / screen_stall); a beat moves when
// valid is high and stall is low. Camera position, yaw, pitch and field of
// view are written through wr_en / wr_addr / wr_data; the user must write
// them only while no point is in flight, as the block does not enforce it.
// Writes to unknown indexes are dropped. One point is accepted every cycle
// while the screen channel is not stalled. The field-of-view divider has a
// quotient width of 17 + clog2(2*(SIZE/2)+1) bits. Most of the pipeline
// depth comes from the 29-stage root of the planar distance feeding the
// pitch CORDIC (20 rotation stages) and the one-bit-per-stage restoring
// divider. All stages share one enable: while the screen beat is stalled the
// whole pipeline holds and point_stall is raised. Reset empties the pipeline
// and loads the camera defaults.
module angular_point_projection
  import app_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CFG_W-1:0]  wr_data,
  input  point_t            point,
  input  logic              point_valid,
  output logic              point_stall,
  output screen_t           screen,
  input  logic              screen_stall,
  output logic              screen_valid
);

  `include "assert_macros.svh"

  logic signed [COORD_W-1:0] cam_x, cam_y, cam_z;
  logic signed [ROT_W-1:0]   cam_yaw, cam_pitch;
  logic [FOV_W-1:0]          fov, fov_eff;

  logic                      en;
  logic                      v1;
  logic signed [DELTA_W-1:0] dx, dy, dz;
  logic signed [DELTA_W-1:0] dlx [0:SQRT_LAT-1];
  logic signed [DELTA_W-1:0] dly [0:SQRT_LAT-1];
  logic signed [DELTA_W-1:0] dlz [0:SQRT_LAT-1];

  logic                     root_vld;
  logic [ROOT_W-1:0]        root;
  logic signed [CORD_W-1:0] col_x, col_y, row_x, row_y;
  logic                     col_vld, row_vld, dcol_vld, drow_vld;
  logic signed [ANG_W-1:0]  col_ang, row_ang;
  logic signed [15:0]       col, row;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x     <= -16'sd100;
      cam_y     <= '0;
      cam_z     <= '0;
      cam_yaw   <= '0;
      cam_pitch <= '0;
      fov       <= 14'd6431;
    end else if (wr_en) begin
      unique case (wr_addr)
        REG_CAM_POS_X: cam_x     <= wr_data;
        REG_CAM_POS_Y: cam_y     <= wr_data;
        REG_CAM_POS_Z: cam_z     <= wr_data;
        REG_CAM_YAW:   cam_yaw   <= wr_data[ROT_W-1:0];
        REG_CAM_PITCH: cam_pitch <= wr_data[ROT_W-1:0];
        REG_FOV:       fov       <= wr_data[FOV_W-1:0];
        default: ;
      endcase
    end
  end

  assign fov_eff     = (fov == '0) ? FOV_W'(1) : fov;
  assign en          = !(screen_valid && screen_stall);
  assign point_stall = !en;

  // offset from camera
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= point_valid;
    end
    if (en) begin
      dx <= $signed({point.point_x[COORD_W-1], point.point_x})
            - $signed({cam_x[COORD_W-1], cam_x});
      dy <= $signed({point.point_y[COORD_W-1], point.point_y})
            - $signed({cam_y[COORD_W-1], cam_y});
      dz <= $signed({point.point_z[COORD_W-1], point.point_z})
            - $signed({cam_z[COORD_W-1], cam_z});
    end
  end

  app_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v1),
    .dx      (dx),
    .dy      (dy),
    .out_vld (root_vld),
    .root    (root)
  );

  // hold the offsets until the distance root is ready
  always_ff @(posedge clk) begin
    if (en) begin
      dlx[0] <= dx;
      dly[0] <= dy;
      dlz[0] <= dz;
      for (int k = 1; k < SQRT_LAT; k++) begin
        dlx[k] <= dlx[k-1];
        dly[k] <= dly[k-1];
        dlz[k] <= dlz[k-1];
      end
    end
  end

  assign col_x = $signed({{(CORD_W-DELTA_W-12){dlx[SQRT_LAT-1][DELTA_W-1]}},
                          dlx[SQRT_LAT-1], 12'b0});
  assign col_y = $signed({{(CORD_W-DELTA_W-12){dly[SQRT_LAT-1][DELTA_W-1]}},
                          dly[SQRT_LAT-1], 12'b0});
  assign row_x = $signed({{(CORD_W-ROOT_W){1'b0}}, root});
  assign row_y = $signed({{(CORD_W-DELTA_W-12){dlz[SQRT_LAT-1][DELTA_W-1]}},
                          dlz[SQRT_LAT-1], 12'b0});

  app_cordic u_cordic_col (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (root_vld),
    .x       (col_x),
    .y       (col_y),
    .out_vld (col_vld),
    .angle   (col_ang)
  );

  app_cordic u_cordic_row (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (root_vld),
    .x       (row_x),
    .y       (row_y),
    .out_vld (row_vld),
    .angle   (row_ang)
  );

  app_div #(.SIZE(SCREEN_WIDTH)) u_div_col (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (col_vld),
    .ang     (col_ang),
    .off     (cam_yaw),
    .fov     (fov_eff),
    .out_vld (dcol_vld),
    .result  (col)
  );

  app_div #(.SIZE(SCREEN_HEIGHT)) u_div_row (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (row_vld),
    .ang     (row_ang),
    .off     (cam_pitch),
    .fov     (fov_eff),
    .out_vld (drow_vld),
    .result  (row)
  );

  assign screen_valid      = dcol_vld;
  assign screen.screen_col = col;
  assign screen.screen_row = row;

  `AP_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !screen_valid, "result valid after reset")
  `AP_ASSERT(a_hold_front, clk, rst, !en |=> $stable(dx) && $stable(dz), "front stage moved")
  `AP_ASSERT(a_lanes_cordic, clk, rst, col_vld == row_vld, "CORDIC lanes out of step")
  `AP_ASSERT(a_lanes_div, clk, rst, dcol_vld == drow_vld, "divider lanes out of step")

endmodule
